[src/hsl2rgb_pkg.sv]
// Shared constants, widths and the stage-enable type for the HSL to RGB converter.
// No dependencies; every other file of the block refers to this package by scoped names.
package hsl2rgb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HUE_W     = FRAC_BITS;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int CHAN_W    = 8;
  localparam int QW        = FRAC_BITS + 1;
  localparam int UW        = FRAC_BITS + 3;
  localparam int NSTG      = 6;

  localparam logic [QW-1:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [QW-1:0] HALF_Q = {2'b01, {(FRAC_BITS-1){1'b0}}};

  typedef struct packed {
    logic [2:0] front;
    logic [2:0] ramp;
  } stg_en_t;

endpackage

[src/hsl2rgb_front.sv]
// Front end of the converter: clamp, q/p computation and hue ramp positions (stages 1 to 3).
// Depends on hsl2rgb_pkg.
module hsl2rgb_front (
  input  logic                           clk,
  input  hsl2rgb_pkg::stg_en_t           en,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]  hue_turn,
  input  logic [hsl2rgb_pkg::FRAC_W-1:0] saturation,
  input  logic [hsl2rgb_pkg::FRAC_W-1:0] lightness,
  output logic [hsl2rgb_pkg::QW-1:0]     p_val,
  output logic [hsl2rgb_pkg::QW-1:0]     d_val,
  output logic [hsl2rgb_pkg::QW-1:0]     t_red,
  output logic [hsl2rgb_pkg::QW-1:0]     t_green,
  output logic [hsl2rgb_pkg::QW-1:0]     t_blue
);

  localparam int F   = hsl2rgb_pkg::FRAC_BITS;
  localparam int QW  = hsl2rgb_pkg::QW;
  localparam int UW  = hsl2rgb_pkg::UW;
  localparam int PW  = 2 * QW + 1;
  localparam int Q2W = 2 * F + 1;

  localparam logic [UW-1:0]  ONE_U   = {3'b001, {F{1'b0}}};
  localparam logic [UW-1:0]  TWO_U   = {3'b010, {F{1'b0}}};
  localparam logic [UW-1:0]  THREE_U = {3'b011, {F{1'b0}}};
  localparam logic [UW-1:0]  FOUR_U  = {3'b100, {F{1'b0}}};
  localparam logic [UW:0]    SIX_UX  = {4'b0110, {F{1'b0}}};
  localparam logic [Q2W-1:0] RND_Q2  = {{(F+2){1'b0}}, {(F-1){1'b0}}} | (Q2W'(1) << (F - 1));

  // Position on the ramp: rise over the first sixth, flat top, fall over the fourth sixth.
  function automatic logic [QW-1:0] ramp_pos(input logic [UW-1:0] u);
    logic [UW-1:0] back;
    back = FOUR_U - u;
    if (u < ONE_U)        ramp_pos = u[QW-1:0];
    else if (u < THREE_U) ramp_pos = hsl2rgb_pkg::ONE_Q;
    else if (u < FOUR_U)  ramp_pos = back[QW-1:0];
    else                  ramp_pos = '0;
  endfunction

  // Stage 1
  logic [QW-1:0] s_c, l_c;
  logic          lo_nxt;
  logic [QW:0]   mul_b;
  logic [PW-1:0] prod1_nxt, prod1_r;
  logic [QW:0]   sum1_nxt, sum1_r;
  logic          lo1_r;
  logic [QW-1:0] l1_r;
  logic [UW-1:0] u1_nxt, u1_r;

  always_comb begin
    s_c       = (saturation > hsl2rgb_pkg::ONE_Q) ? hsl2rgb_pkg::ONE_Q : saturation;
    l_c       = (lightness > hsl2rgb_pkg::ONE_Q) ? hsl2rgb_pkg::ONE_Q : lightness;
    lo_nxt    = l_c < hsl2rgb_pkg::HALF_Q;
    mul_b     = lo_nxt ? ({1'b0, hsl2rgb_pkg::ONE_Q} + {1'b0, s_c}) : {1'b0, s_c};
    prod1_nxt = PW'(l_c) * PW'(mul_b);
    sum1_nxt  = {1'b0, l_c} + {1'b0, s_c};
    u1_nxt    = {1'b0, hue_turn[F-1:0], 2'b00} + {2'b00, hue_turn[F-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en.front[0]) begin
      prod1_r <= prod1_nxt;
      sum1_r  <= sum1_nxt;
      lo1_r   <= lo_nxt;
      l1_r    <= l_c;
      u1_r    <= u1_nxt;
    end
  end

  // Stage 2: finish q2 and rotate hue for red and blue
  logic [PW-1:0]  diff2;
  logic [Q2W-1:0] q2_nxt, q2_r;
  logic [UW-1:0]  ur_tmp, ur_nxt, ur2_r, ug2_r, ub2_r;
  logic [UW:0]    ub_tmp, ub_sub;
  logic [QW-1:0]  l2_r;

  always_comb begin
    diff2  = {1'b0, sum1_r, {F{1'b0}}} - prod1_r;
    q2_nxt = lo1_r ? prod1_r[Q2W-1:0] : diff2[Q2W-1:0];
    ur_tmp = u1_r + TWO_U;
    ur_nxt = (ur_tmp >= SIX_UX[UW-1:0]) ? (ur_tmp - SIX_UX[UW-1:0]) : ur_tmp;
    ub_tmp = {1'b0, u1_r} + {1'b0, FOUR_U};
    ub_sub = (ub_tmp >= SIX_UX) ? (ub_tmp - SIX_UX) : ub_tmp;
  end

  always_ff @(posedge clk) begin
    if (en.front[1]) begin
      q2_r  <= q2_nxt;
      l2_r  <= l1_r;
      ur2_r <= ur_nxt;
      ug2_r <= u1_r;
      ub2_r <= ub_sub[UW-1:0];
    end
  end

  // Stage 3: round q, form p and the slope d, pick ramp positions
  logic [Q2W-1:0] qr;
  logic [QW-1:0]  q3;
  logic [QW:0]    p_full;
  logic [QW-1:0]  p_nxt, d_nxt;
  logic [QW-1:0]  p3_r, d3_r, tr3_r, tg3_r, tb3_r;

  always_comb begin
    qr     = q2_r + RND_Q2;
    q3     = qr[F +: QW];
    p_full = {l2_r, 1'b0} - {1'b0, q3};
    p_nxt  = p_full[QW-1:0];
    d_nxt  = q3 - p_nxt;
  end

  always_ff @(posedge clk) begin
    if (en.front[2]) begin
      p3_r  <= p_nxt;
      d3_r  <= d_nxt;
      tr3_r <= ramp_pos(ur2_r);
      tg3_r <= ramp_pos(ug2_r);
      tb3_r <= ramp_pos(ub2_r);
    end
  end

  assign p_val   = p3_r;
  assign d_val   = d3_r;
  assign t_red   = tr3_r;
  assign t_green = tg3_r;
  assign t_blue  = tb3_r;

endmodule

[src/hsl2rgb_ramp.sv]
// One color channel: ramp value p + d*t and rounding of value*255 to 8 bits (stages 4 to 6).
// Depends on hsl2rgb_pkg.
module hsl2rgb_ramp (
  input  logic                           clk,
  input  hsl2rgb_pkg::stg_en_t           en,
  input  logic [hsl2rgb_pkg::QW-1:0]     p_val,
  input  logic [hsl2rgb_pkg::QW-1:0]     d_val,
  input  logic [hsl2rgb_pkg::QW-1:0]     t_val,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] chan
);

  localparam int F  = hsl2rgb_pkg::FRAC_BITS;
  localparam int QW = hsl2rgb_pkg::QW;
  localparam int VW = 2 * QW;
  localparam int WW = VW + 8;
  localparam logic [WW-1:0] RND_W = WW'(1) << (2 * F - 1);

  logic [VW-1:0] prod4_r;
  logic [QW-1:0] p4_r;
  logic [VW-1:0] v5_nxt, v5_r;
  logic [WW-1:0] w6;
  logic [hsl2rgb_pkg::CHAN_W-1:0] chan_r;

  always_ff @(posedge clk) begin
    if (en.ramp[0]) begin
      prod4_r <= VW'(d_val) * VW'(t_val);
      p4_r    <= p_val;
    end
  end

  assign v5_nxt = {1'b0, p4_r, {F{1'b0}}} + prod4_r;

  always_ff @(posedge clk) begin
    if (en.ramp[1]) begin
      v5_r <= v5_nxt;
    end
  end

  // value*255 as shift and subtract, then round half up
  assign w6 = {v5_r, 8'b0} - {8'b0, v5_r} + RND_W;

  always_ff @(posedge clk) begin
    if (en.ramp[2]) begin
      chan_r <= w6[2*F +: hsl2rgb_pkg::CHAN_W];
    end
  end

  assign chan = chan_r;

endmodule

[src/hsl_to_rgb_convert_core.sv]
// HSL/HSLA to 8-bit RGBA converter, six register stages deep.
// Throughput: one beat per cycle if in_stall is low; per-stage valid bits close bubbles under stall.
// Reset: synchronous active-low rst_n clears all stage valid bits; datapath registers are not reset.
// Depends on hsl2rgb_pkg, hsl2rgb_front and hsl2rgb_ramp.
module hsl_to_rgb_convert_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]  in_hue_turn,
  input  logic [hsl2rgb_pkg::FRAC_W-1:0] in_saturation,
  input  logic [hsl2rgb_pkg::FRAC_W-1:0] in_lightness,
  input  logic [hsl2rgb_pkg::FRAC_W-1:0] in_alpha_frac,
  input  logic                           in_has_alpha,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] out_red,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] out_green,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] out_blue,
  output logic [hsl2rgb_pkg::CHAN_W-1:0] out_alpha
);

  localparam int NSTG = hsl2rgb_pkg::NSTG;
  localparam int F    = hsl2rgb_pkg::FRAC_BITS;
  localparam int AW   = hsl2rgb_pkg::FRAC_W + 8;

  // Stage valid bits and the ready chain. A stage may load when it is empty
  // or when the stage after it moves on in the same cycle.
  logic [NSTG-1:0] vld_r, vld_nxt, rdy;
  hsl2rgb_pkg::stg_en_t en;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en.front = rdy[2:0];
  assign en.ramp  = rdy[5:3];
  assign in_stall = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

  // Shared front end: q, p, slope and per-channel ramp positions.
  logic [hsl2rgb_pkg::QW-1:0] p_val, d_val, t_red, t_green, t_blue;

  hsl2rgb_front u_front (
    .clk        (clk),
    .en         (en),
    .hue_turn   (in_hue_turn),
    .saturation (in_saturation),
    .lightness  (in_lightness),
    .p_val      (p_val),
    .d_val      (d_val),
    .t_red      (t_red),
    .t_green    (t_green),
    .t_blue     (t_blue)
  );

  // One ramp evaluator per color channel. Zero saturation needs no bypass:
  // it yields q = p = lightness and slope zero, so each channel rounds l*255.
  hsl2rgb_ramp u_ramp_red (
    .clk   (clk),
    .en    (en),
    .p_val (p_val),
    .d_val (d_val),
    .t_val (t_red),
    .chan  (out_red)
  );

  hsl2rgb_ramp u_ramp_green (
    .clk   (clk),
    .en    (en),
    .p_val (p_val),
    .d_val (d_val),
    .t_val (t_green),
    .chan  (out_green)
  );

  hsl2rgb_ramp u_ramp_blue (
    .clk   (clk),
    .en    (en),
    .p_val (p_val),
    .d_val (d_val),
    .t_val (t_blue),
    .chan  (out_blue)
  );

  // Alpha: truncate a*255, saturate to 255, or force 255 without an alpha field.
  // Compute in stage 1, then hold it alongside the color data.
  logic [AW-1:0]                   a255;
  logic [8:0]                      a_int;
  logic [hsl2rgb_pkg::CHAN_W-1:0]  alpha_nxt;
  logic [hsl2rgb_pkg::CHAN_W-1:0]  alpha_r [NSTG];

  always_comb begin
    a255      = {in_alpha_frac, 8'b0} - {8'b0, in_alpha_frac};
    a_int     = a255[F +: 9];
    alpha_nxt = !in_has_alpha ? 8'hFF : (a_int[8] ? 8'hFF : a_int[7:0]);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      alpha_r[0] <= alpha_nxt;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        alpha_r[k] <= alpha_r[k-1];
      end
    end
  end

  assign out_alpha = alpha_r[NSTG-1];

endmodule

[src/hsl2rgb_chk.sv]
// Port-level checker for hsl_to_rgb_convert_core, attached with a bind statement below.
// Depends on hsl2rgb_pkg and the top level's ports.
module hsl2rgb_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [hsl2rgb_pkg::HUE_W-1:0]  in_hue_turn,
  input logic [hsl2rgb_pkg::FRAC_W-1:0] in_saturation,
  input logic [hsl2rgb_pkg::FRAC_W-1:0] in_lightness,
  input logic [hsl2rgb_pkg::FRAC_W-1:0] in_alpha_frac,
  input logic                           in_has_alpha,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] out_red,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] out_green,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] out_blue,
  input logic [hsl2rgb_pkg::CHAN_W-1:0] out_alpha
);

  // Hold a stalled output beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_red, out_green, out_blue, out_alpha}))
    else $error("stalled output beat changed");

  // Input stall only with a full pipe blocked at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Reset drains the pipe.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

endmodule

bind hsl_to_rgb_convert_core hsl2rgb_chk u_hsl2rgb_chk (.*);
